FILE: rtl/core/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared constants, register codes and the queue word type of the planar
// sprite blitter.
// ----------------------------------------------------------------------------
package psb_pkg;

    // Parameter defaults
    localparam int SCREEN_W_DEF      = 320;
    localparam int SCREEN_H_DEF      = 200;
    localparam int MAX_ROW_BYTES_DEF = 32;
    localparam int MAX_ROWS_DEF      = 256;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // Pixels per planar byte group
    localparam int PIX    = 8;
    localparam int ADDR_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUIRK_EN  = 2'd1;

    // Request types
    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    // One classified group: base address of pixel 0, per-pixel value,
    // merge flag and write-enable mask (bit i is pixel i from the left).
    typedef struct packed {
        logic [ADDR_W-1:0]       base;
        logic [PIX-1:0][7:0]     vals;
        logic [PIX-1:0]          merge;
        logic [PIX-1:0]          mask;
    } psb_group_t;

endpackage

FILE: rtl/core/psb_front.sv
// ----------------------------------------------------------------------------
// psb_front
// Accepts command and data words, tracks the blit position and classifies
// each data group into a word of pixel writes for the queue.
// ----------------------------------------------------------------------------
module psb_front #(
    parameter int SCREEN_W      = psb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H      = psb_pkg::SCREEN_H_DEF,
    parameter int MAX_ROW_BYTES = psb_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_ROWS      = psb_pkg::MAX_ROWS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic signed [10:0]                pos_x,
    input  logic signed [10:0]                pos_y,
    input  logic [5:0]                        width_bytes,
    input  logic [8:0]                        height_rows,
    input  logic                              recolor,
    input  logic [7:0]                        solid_color,
    input  logic [7:0]                        plane3_bits,
    input  logic [7:0]                        plane2_bits,
    input  logic [7:0]                        plane1_bits,
    input  logic [7:0]                        plane0_bits,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psb_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              q_full,
    output logic                              q_push,
    output psb_pkg::psb_group_t               q_word
);
    import psb_pkg::*;

    localparam int XW = $clog2(1024 + 8 * MAX_ROW_BYTES) + 1;
    localparam int YW = $clog2(1024 + MAX_ROWS) + 1;
    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    localparam logic signed [XW-1:0] SCR_W_X   = XW'(SCREEN_W);
    localparam logic signed [YW-1:0] SCR_H_Y   = YW'(SCREEN_H);
    localparam logic [ADDR_W-1:0]    ROW_STEP  = ADDR_W'(SCREEN_W);
    localparam logic signed [XW-1:0] BYTE_STEP = XW'(PIX);

    // Configuration
    logic [7:0]              clip_top_reg, clip_top_next;
    logic                    quirk_reg, quirk_next;

    // Blit state
    logic                    active_reg, active_next;
    logic signed [XW-1:0]    org_x_reg, org_x_next;
    logic signed [XW-1:0]    cur_x_reg, cur_x_next;
    logic signed [YW-1:0]    cur_y_reg, cur_y_next;
    logic [ADDR_W-1:0]       row_base_reg, row_base_next;
    logic [CW-1:0]           col_reg, col_next;
    logic [CW-1:0]           row_bytes_reg, row_bytes_next;
    logic [RW-1:0]           row_reg, row_next;
    logic [RW-1:0]           rows_reg, rows_next;
    logic                    recolor_reg, recolor_next;
    logic [7:0]              fill_reg, fill_next;
    logic [1:0]              lead_reg, lead_next;

    logic                    accept;
    logic                    row_ok;
    logic signed [YW-1:0]    clip_y;
    logic [CW-1:0]           w_sat;
    logic [RW-1:0]           h_sat;
    logic [CW-1:0]           col_inc;
    logic [RW-1:0]           row_inc;
    logic [ADDR_W-1:0]       pos_y_16;
    psb_group_t              grp;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    assign clip_y  = YW'(clip_top_reg);
    assign row_ok  = (cur_y_reg >= clip_y) && (cur_y_reg < SCR_H_Y);
    assign col_inc = col_reg + CW'(1);
    assign row_inc = row_reg + RW'(1);
    assign pos_y_16 = {{(ADDR_W - 11){pos_y[10]}}, pos_y};

    assign w_sat = ({26'd0, width_bytes} > MAX_ROW_BYTES) ? CW'(MAX_ROW_BYTES)
                                                         : CW'(width_bytes);
    assign h_sat = ({23'd0, height_rows} > MAX_ROWS) ? RW'(MAX_ROWS)
                                                    : RW'(height_rows);

    // Classify the eight pixels of the current group
    always_comb
    begin
        logic signed [XW-1:0] px_x;
        logic [3:0]           color;
        logic                 in_x;
        grp      = '0;
        grp.base = row_base_reg + ADDR_W'(cur_x_reg);
        for (int i = 0; i < PIX; i++)
        begin
            px_x  = cur_x_reg + XW'(i);
            color = {plane3_bits[PIX-1-i], plane2_bits[PIX-1-i],
                     plane1_bits[PIX-1-i], plane0_bits[PIX-1-i]};
            in_x  = !px_x[XW-1] && (px_x < SCR_W_X);
            grp.mask[i]  = row_ok && in_x && (color != 4'd0);
            grp.vals[i]  = recolor_reg ? fill_reg : {4'd0, color};
            grp.merge[i] = !recolor_reg && (col_reg == '0)
                           && (3'(i) < {1'b0, lead_reg}) && !color[0];
        end
    end

    assign q_word = grp;
    assign q_push = accept && (req_type == REQ_DATA) && active_reg && (|grp.mask);

    // Configuration writes
    always_comb
    begin
        clip_top_next = clip_top_reg;
        quirk_next    = quirk_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CLIP_TOP: clip_top_next = cfg_data;
                REG_QUIRK_EN: quirk_next    = cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Blit position tracking
    always_comb
    begin
        active_next    = active_reg;
        org_x_next     = org_x_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        row_base_next  = row_base_reg;
        col_next       = col_reg;
        row_bytes_next = row_bytes_reg;
        row_next       = row_reg;
        rows_next      = rows_reg;
        recolor_next   = recolor_reg;
        fill_next      = fill_reg;
        lead_next      = lead_reg;
        if (accept && (req_type == REQ_CMD))
        begin
            org_x_next     = {{(XW - 11){pos_x[10]}}, pos_x};
            cur_x_next     = {{(XW - 11){pos_x[10]}}, pos_x};
            cur_y_next     = {{(YW - 11){pos_y[10]}}, pos_y};
            row_base_next  = pos_y_16 * ROW_STEP;
            col_next       = '0;
            row_next       = '0;
            row_bytes_next = w_sat;
            rows_next      = h_sat;
            recolor_next   = recolor;
            fill_next      = solid_color;
            lead_next      = (quirk_reg && !pos_x[10] && (pos_x[2:1] == 2'b11))
                             ? (pos_x[0] ? 2'd1 : 2'd2) : 2'd0;
            active_next    = (w_sat != '0) && (h_sat != '0);
        end
        else if (accept && active_reg)
        begin
            if (col_inc >= row_bytes_reg)
            begin
                col_next      = '0;
                cur_x_next    = org_x_reg;
                row_next      = row_inc;
                cur_y_next    = cur_y_reg + YW'(1);
                row_base_next = row_base_reg + ROW_STEP;
                if (row_inc >= rows_reg)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                col_next   = col_inc;
                cur_x_next = cur_x_reg + BYTE_STEP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_top_reg  <= '0;
            quirk_reg     <= 1'b0;
            active_reg    <= 1'b0;
            org_x_reg     <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            row_base_reg  <= '0;
            col_reg       <= '0;
            row_bytes_reg <= '0;
            row_reg       <= '0;
            rows_reg      <= '0;
            recolor_reg   <= 1'b0;
            fill_reg      <= '0;
            lead_reg      <= '0;
        end
        else
        begin
            clip_top_reg  <= clip_top_next;
            quirk_reg     <= quirk_next;
            active_reg    <= active_next;
            org_x_reg     <= org_x_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            row_base_reg  <= row_base_next;
            col_reg       <= col_next;
            row_bytes_reg <= row_bytes_next;
            row_reg       <= row_next;
            rows_reg      <= rows_next;
            recolor_reg   <= recolor_next;
            fill_reg      <= fill_next;
            lead_reg      <= lead_next;
        end
    end

endmodule

FILE: rtl/core/psb_queue.sv
// ----------------------------------------------------------------------------
// psb_queue
// Short first-in first-out queue of classified groups between the front
// and back parts.
// ----------------------------------------------------------------------------
module psb_queue #(
    parameter int DEPTH = psb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  psb_pkg::psb_group_t   push_word,
    input  logic                  pop,
    output psb_pkg::psb_group_t   head_word,
    output logic                  empty,
    output logic                  full
);
    import psb_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    psb_group_t        slots [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]    count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNW'(DEPTH));
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_word = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: rtl/core/psb_back.sv
// ----------------------------------------------------------------------------
// psb_back
// Takes classified groups from the queue and issues their pixel writes, one
// per cycle unless out_ready stalls, leftmost first, via an output register.
// ----------------------------------------------------------------------------
module psb_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  psb_pkg::psb_group_t         q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [psb_pkg::ADDR_W-1:0]  pixel_address,
    output logic [7:0]                  pixel_value,
    output logic                        merge_or,
    output logic                        last_of_run
);
    import psb_pkg::*;

    psb_group_t         work_reg, work_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [7:0]         value_reg, value_next;
    logic               merge_reg, merge_next;
    logic               last_reg, last_next;

    logic [2:0]         sel;
    logic [PIX-1:0]     rest;
    logic [PIX-1:0]     after_mask;
    logic               out_free;
    logic               emit;

    // Leftmost pending pixel
    always_comb
    begin
        sel = '0;
        for (int i = PIX - 1; i >= 0; i--)
        begin
            if (work_reg.mask[i])
            begin
                sel = 3'(i);
            end
        end
    end

    assign rest       = work_reg.mask & ~(PIX'(1) << sel);
    assign out_free   = !out_valid_reg || out_ready;
    assign emit       = (|work_reg.mask) && out_free;
    assign after_mask = emit ? rest : work_reg.mask;
    assign q_pop      = !q_empty && (after_mask == '0);

    always_comb
    begin
        work_next      = work_reg;
        work_next.mask = after_mask;
        if (q_pop)
        begin
            work_next = q_head;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        addr_next      = addr_reg;
        value_next     = value_reg;
        merge_next     = merge_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            addr_next      = work_reg.base + ADDR_W'(sel);
            value_next     = work_reg.vals[sel];
            merge_next     = work_reg.merge[sel];
            last_next      = (rest == '0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            work_reg      <= work_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        value_reg <= value_next;
        merge_reg <= merge_next;
        last_reg  <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign pixel_address = addr_reg;
    assign pixel_value   = value_reg;
    assign merge_or      = merge_reg;
    assign last_of_run   = last_reg;

endmodule

FILE: rtl/core/planar_sprite_blitter_core.sv
// ----------------------------------------------------------------------------
// planar_sprite_blitter_core
// Planar sprite blitter: turns a blit command and planar byte groups into
// clipped framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): a command word (req_type 0) sets origin,
//   size, recolor mode and fill color; data words (req_type 1) then bring the
//   four plane bytes of each 8-pixel group, row-major, MSB leftmost.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   clip_top, index 1 is the quirk enable; cfg_ready is always high. Write it
//   only while no words are in flight.
//   Output channel (out_valid/out_ready): one pixel write per word, the last
//   write of a data group carries last_of_run.
//   Timing: a data word is classified in the cycle it is accepted and queued;
//   its first pixel write then passes the queue, the back end's work register
//   and the output register. The back end issues one pixel per cycle while
//   out_ready is high, one write per visible opaque pixel of a group (up to 8);
//   a command, an empty or fully clipped group produces nothing.
//   The front takes a word per cycle while the queue has room.
//   Stall: when out_ready is low the output word holds, the back end stops,
//   the queue fills and in_ready drops once it is full.
//   Reset: no blit armed, clip_top 0, quirk off, queue and output empty.
// ----------------------------------------------------------------------------
module planar_sprite_blitter_core #(
    parameter int SCREEN_W      = psb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H      = psb_pkg::SCREEN_H_DEF,
    parameter int MAX_ROW_BYTES = psb_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_ROWS      = psb_pkg::MAX_ROWS_DEF,
    parameter int QUEUE_DEPTH   = psb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input words
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic signed [10:0]                pos_x,
    input  logic signed [10:0]                pos_y,
    input  logic [5:0]                        width_bytes,
    input  logic [8:0]                        height_rows,
    input  logic                              recolor,
    input  logic [7:0]                        solid_color,
    input  logic [7:0]                        plane3_bits,
    input  logic [7:0]                        plane2_bits,
    input  logic [7:0]                        plane1_bits,
    input  logic [7:0]                        plane0_bits,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psb_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel writes
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psb_pkg::ADDR_W-1:0]        pixel_address,
    output logic [7:0]                        pixel_value,
    output logic                              merge_or,
    output logic                              last_of_run
);
    import psb_pkg::*;

    // Front to queue, queue to back
    logic          q_push;
    psb_group_t    q_word;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    psb_group_t    q_head;

    // Front: accept, track position, clip and classify each group
    psb_front #(
        .SCREEN_W      (SCREEN_W),
        .SCREEN_H      (SCREEN_H),
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .width_bytes (width_bytes),
        .height_rows (height_rows),
        .recolor     (recolor),
        .solid_color (solid_color),
        .plane3_bits (plane3_bits),
        .plane2_bits (plane2_bits),
        .plane1_bits (plane1_bits),
        .plane0_bits (plane0_bits),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_word      (q_word)
    );

    // Decouple the two sides; only groups with visible pixels enter
    psb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_word),
        .pop       (q_pop),
        .head_word (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: serialize each group into pixel writes
    psb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_value   (pixel_value),
        .merge_or      (merge_or),
        .last_of_run   (last_of_run)
    );

endmodule

FILE: rtl/core/psb_checker.sv
// ----------------------------------------------------------------------------
// psb_checker
// Port-level checks of the planar sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
module psb_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [psb_pkg::ADDR_W-1:0]  pixel_address,
    input  logic [7:0]                  pixel_value,
    input  logic                        merge_or,
    input  logic                        last_of_run
);

    // No write shows at the edge where reset is released
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("pixel write valid at reset release");

    // A stalled write holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_address)
            && $stable(pixel_value) && $stable(merge_or) && $stable(last_of_run))
        else $error("stalled pixel write changed");

    // A group's writes follow each other without a gap
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside a group's pixel writes");

    // Merge writes only carry even, non-zero 4-bit colors
    a_merge_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && merge_or |-> (pixel_value[7:4] == 4'd0) && !pixel_value[0]
            && (pixel_value != 8'd0))
        else $error("merge write with bad color");

endmodule

bind planar_sprite_blitter_core psb_checker u_psb_checker (.*);

FILE: tb/planar_sprite_blitter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// planar_sprite_blitter_core_tb
// Self-checking bench for the planar sprite blitter. A behavioral model of
// the blitter predicts every framebuffer write from the accepted words; the
// monitor compares each write on the output channel against the oldest
// prediction. Directed sprites cover clipping, recolor, the lead-column
// merge quirk and size edge cases; random sprites follow, with bursty input
// traffic and a patterned stall on the output.
// ----------------------------------------------------------------------------
module planar_sprite_blitter_core_tb;

    import psb_pkg::*;

    localparam int SCREEN_W      = SCREEN_W_DEF;
    localparam int SCREEN_H      = SCREEN_H_DEF;
    localparam int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF;
    localparam int MAX_ROWS      = MAX_ROWS_DEF;

    // Cycles to let pass once nothing is due, before a register write or
    // the end of the run: covers groups that finish without a write.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 20000;
    localparam int RUN_LIMIT     = 400000;
    localparam int RANDOM_WORDS  = 440;

    // One word on the input channel, command and plane fields side by side
    typedef struct {
        logic               kind;
        logic signed [10:0] x;
        logic signed [10:0] y;
        logic [5:0]         w;
        logic [8:0]         h;
        logic               rc;
        logic [7:0]         fill;
        logic [7:0]         p3;
        logic [7:0]         p2;
        logic [7:0]         p1;
        logic [7:0]         p0;
    } blit_word_t;

    // One framebuffer write as the block should emit it
    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [7:0]        value;
        logic              merge;
        logic              last_flag;
    } pixel_write_t;

    typedef enum {RX_STEADY, RX_COIN, RX_PERIODIC, RX_STRETCH} rx_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    logic                   req_type    = REQ_CMD;
    logic signed [10:0]     pos_x       = '0;
    logic signed [10:0]     pos_y       = '0;
    logic [5:0]             width_bytes = '0;
    logic [8:0]             height_rows = '0;
    logic                   recolor     = 1'b0;
    logic [7:0]             solid_color = '0;
    logic [7:0]             plane3_bits = '0;
    logic [7:0]             plane2_bits = '0;
    logic [7:0]             plane1_bits = '0;
    logic [7:0]             plane0_bits = '0;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index   = REG_CLIP_TOP;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [ADDR_W-1:0]      pixel_address;
    logic [7:0]             pixel_value;
    logic                   merge_or;
    logic                   last_of_run;

    // Blitter model: registers and the running sprite
    int   clip_row       = 0;
    logic quirk_on       = 1'b0;
    logic sprite_armed   = 1'b0;
    int   sprite_x       = 0;
    int   sprite_y       = 0;
    int   sprite_w       = 0;
    int   sprite_h       = 0;
    logic sprite_recolor = 1'b0;
    logic [7:0] sprite_fill = '0;
    int   lead_cols      = 0;
    int   row_idx        = 0;
    int   src_byte_col   = 0;

    pixel_write_t pixel_writes_due[$];
    int unsigned  words_taken = 0;
    int unsigned  mismatches  = 0;
    int unsigned  cycle_count = 0;
    int           burst_left  = 0;
    rx_mode_t     rx_mode     = RX_STEADY;

    planar_sprite_blitter_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .width_bytes   (width_bytes),
        .height_rows   (height_rows),
        .recolor       (recolor),
        .solid_color   (solid_color),
        .plane3_bits   (plane3_bits),
        .plane2_bits   (plane2_bits),
        .plane1_bits   (plane1_bits),
        .plane0_bits   (plane0_bits),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_value   (pixel_value),
        .merge_or      (merge_or),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model: turn one accepted word into the pixel writes it must cause.
    // A command latches the sprite; a data group is clipped pixel by pixel,
    // then the source position advances whether or not anything was drawn.
    // ------------------------------------------------------------------------
    task automatic rasterize_word();
        pixel_write_t group_writes[$];
        pixel_write_t pw;
        logic [3:0]   color;
        int           dest_row;
        int           src_col;
        int           dest_col;
        if (req_type == REQ_CMD)
        begin
            // Saturate oversize sprites, then arm only a non-empty one
            sprite_w = (width_bytes > MAX_ROW_BYTES) ? MAX_ROW_BYTES : int'(width_bytes);
            sprite_h = (height_rows > MAX_ROWS) ? MAX_ROWS : int'(height_rows);
            sprite_x = pos_x;
            sprite_y = pos_y;
            sprite_recolor = recolor;
            sprite_fill = solid_color;
            // Lead-column quirk is latched with the command, not per group
            lead_cols = 0;
            if (quirk_on && sprite_x >= 0 && sprite_x % PIX >= 6)
                lead_cols = PIX - sprite_x % PIX;
            row_idx = 0;
            src_byte_col = 0;
            sprite_armed = (sprite_w != 0 && sprite_h != 0);
            return;
        end
        // Drop stray groups: nothing armed, or the sprite is already done
        if (!sprite_armed)
            return;
        dest_row = sprite_y + row_idx;
        if (dest_row >= clip_row && dest_row < SCREEN_H)
        begin
            for (int i = 0; i < PIX; i++)
            begin
                src_col = src_byte_col * PIX + i;
                dest_col = sprite_x + src_col;
                color = {plane3_bits[7-i], plane2_bits[7-i], plane1_bits[7-i],
                         plane0_bits[7-i]};
                // Skip off-screen columns and transparent pixels
                if (dest_col < 0 || dest_col >= SCREEN_W || color == 4'd0)
                    continue;
                pw.address = ADDR_W'(dest_row * SCREEN_W + dest_col);
                pw.value = sprite_recolor ? sprite_fill : {4'd0, color};
                pw.merge = !sprite_recolor && src_col < lead_cols && !color[0];
                pw.last_flag = 1'b0;
                group_writes.push_back(pw);
            end
            if (group_writes.size() > 0)
                group_writes[group_writes.size()-1].last_flag = 1'b1;
            foreach (group_writes[j])
                pixel_writes_due.push_back(group_writes[j]);
        end
        src_byte_col++;
        if (src_byte_col >= sprite_w)
        begin
            src_byte_col = 0;
            row_idx++;
            if (row_idx >= sprite_h)
                sprite_armed = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. One process handles all three channels at each edge, so the
    // order is fixed: register writes, then the output check, then the
    // prediction for the word accepted at this edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        pixel_write_t due;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CLIP_TOP: clip_row = int'(cfg_data);
                    REG_QUIRK_EN: quirk_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (pixel_writes_due.size() == 0)
                begin
                    $error("pixel write with none due: address %0d value %0d",
                           pixel_address, pixel_value);
                    mismatches++;
                end
                else
                begin
                    due = pixel_writes_due.pop_front();
                    if (pixel_address !== due.address)
                    begin
                        $error("pixel_address: expected %0d, got %0d",
                               due.address, pixel_address);
                        mismatches++;
                    end
                    if (pixel_value !== due.value)
                    begin
                        $error("pixel_value: expected %0d, got %0d", due.value, pixel_value);
                        mismatches++;
                    end
                    if (merge_or !== due.merge)
                    begin
                        $error("merge_or: expected %0b, got %0b", due.merge, merge_or);
                        mismatches++;
                    end
                    if (last_of_run !== due.last_flag)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               due.last_flag, last_of_run);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                words_taken++;
                rasterize_word();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output back-pressure: pick a new stall pattern whenever the low byte of the
    // cycle counter is zero, among always ready, coin flips, a fixed 5-of-8 duty
    // and long stretches. Also guard the run against a hang.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        if (cycle_count[7:0] == 8'd0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_STEADY:   out_ready <= 1'b1;
            RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: out_ready <= (cycle_count[2:0] < 3'd5);
            default:     out_ready <= ($urandom_range(0, 9) == 0) ? !out_ready : out_ready;
        endcase
    end

    // ------------------------------------------------------------------------
    // Word builders. Fields the word does not use carry random noise.
    // ------------------------------------------------------------------------
    function automatic blit_word_t make_cmd(input int x, input int y, input int w,
                                            input int h, input logic rc, input int fill);
        blit_word_t bw;
        bw.kind = REQ_CMD;
        bw.x    = 11'(x);
        bw.y    = 11'(y);
        bw.w    = 6'(w);
        bw.h    = 9'(h);
        bw.rc   = rc;
        bw.fill = 8'(fill);
        bw.p3   = 8'($urandom);
        bw.p2   = 8'($urandom);
        bw.p1   = 8'($urandom);
        bw.p0   = 8'($urandom);
        return bw;
    endfunction

    function automatic blit_word_t make_group(input logic [7:0] p3, input logic [7:0] p2,
                                              input logic [7:0] p1, input logic [7:0] p0);
        blit_word_t bw;
        bw      = make_cmd($urandom, $urandom, $urandom, $urandom, 1'($urandom), $urandom);
        bw.kind = REQ_DATA;
        bw.p3   = p3;
        bw.p2   = p2;
        bw.p1   = p1;
        bw.p0   = p0;
        return bw;
    endfunction

    // Mostly dense random groups, with transparent, solid and sparse ones
    function automatic blit_word_t random_group();
        logic [7:0] keep;
        keep = 8'($urandom) & 8'($urandom);
        case ($urandom_range(0, 7))
            0: return make_group(8'h00, 8'h00, 8'h00, 8'h00);
            1: return make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            2: return make_group(8'($urandom) & keep, 8'($urandom) & keep,
                                 8'($urandom) & keep, 8'($urandom) & keep);
            default: return make_group(8'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Input driver. Words go out in bursts; between bursts hold valid low for
    // a random gap. Return at the edge where the word was accepted, with
    // valid still high so the next word can follow without a bubble.
    // ------------------------------------------------------------------------
    task automatic send_word(input blit_word_t bw);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid    <= 1'b1;
        req_type    <= bw.kind;
        pos_x       <= bw.x;
        pos_y       <= bw.y;
        width_bytes <= bw.w;
        height_rows <= bw.h;
        recolor     <= bw.rc;
        solid_color <= bw.fill;
        plane3_bits <= bw.p3;
        plane2_bits <= bw.p2;
        plane1_bits <= bw.p1;
        plane0_bits <= bw.p0;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Hold off input until every due write has come out, then settle
    task automatic drain_writes();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixel_writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic program_regs(input int clip, input logic quirk);
        drain_writes();
        cfg_valid <= 1'b1;
        cfg_index <= REG_CLIP_TOP;
        cfg_data  <= CFG_DATA_W'(clip);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= REG_QUIRK_EN;
        cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, quirk};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Opaque group, transparent group, then a stray group after the sprite
    task automatic test_plain_draw();
        send_word(make_cmd(0, 0, 2, 1, 1'b0, 0));
        send_word(make_group(8'h0F, 8'h33, 8'h55, 8'hF0));
        send_word(make_group(8'h00, 8'h00, 8'h00, 8'h00));
        send_word(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Left and bottom edges, right edge, and far off-screen origins
    task automatic test_clipping();
        send_word(make_cmd(-5, 198, 1, 3, 1'b0, 0));
        send_word(make_group(8'hFF, 8'h00, 8'hA5, 8'h5A));
        send_word(make_group(8'h81, 8'h42, 8'h24, 8'h18));
        send_word(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_cmd(316, 0, 1, 1, 1'b0, 0));
        send_word(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_cmd(1023, -1024, 1, 1, 1'b0, 0));
        send_word(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Oversize sprite abandoned by a zero-size command, then stray data
    task automatic test_size_limits();
        send_word(make_cmd(-1024, 1023, 63, 511, 1'b0, 0));
        send_word(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_cmd(0, 0, 0, 4, 1'b0, 0));
        send_word(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Fill color replaces every opaque pixel; second group is off-screen
    task automatic test_recolor();
        send_word(make_cmd(312, 10, 2, 1, 1'b1, 8'hA5));
        send_word(make_group(8'hF0, 8'h0C, 8'h00, 8'h01));
        send_word(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Lead columns with even colors merge; a negative origin never does
    task automatic test_lead_quirk();
        program_regs(0, 1'b1);
        send_word(make_cmd(6, 20, 2, 1, 1'b0, 0));
        send_word(make_group(8'h0F, 8'h00, 8'hC3, 8'h41));
        send_word(make_group(8'hC0, 8'hFF, 8'hFF, 8'h7F));
        send_word(make_cmd(-2, 20, 1, 1, 1'b0, 0));
        send_word(make_group(8'h00, 8'h00, 8'hFF, 8'h00));
    endtask

    // Clip at the screen bottom blanks every row; one row higher shows one
    task automatic test_clip_top_limit();
        program_regs(200, 1'b0);
        send_word(make_cmd(0, 199, 1, 1, 1'b0, 0));
        send_word(make_group(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        program_regs(199, 1'b1);
        send_word(make_cmd(0, 199, 1, 1, 1'b0, 0));
        send_word(make_group(8'hAA, 8'h55, 8'hFF, 8'h00));
    endtask

    // ------------------------------------------------------------------------
    // Random sprites: mostly well-formed sprites of small size near the clip
    // edges, some cut short or followed by stray groups, plus wild commands,
    // zero-size commands and loose groups.
    // ------------------------------------------------------------------------
    task automatic random_sprite();
        int x;
        int y;
        int w;
        int h;
        int n;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 4);
            case ($urandom_range(0, 3))
                0: x = int'($urandom_range(0, 48)) - 24;
                1: x = $urandom_range(288, 330);
                2: x = PIX * $urandom_range(0, 39) + $urandom_range(6, 7);
                default: x = int'($urandom_range(0, 360)) - 20;
            endcase
            case ($urandom_range(0, 2))
                0: y = int'($urandom_range(0, 12)) - 6;
                1: y = $urandom_range(140, 206);
                default: y = $urandom_range(0, 199);
            endcase
            send_word(make_cmd(x, y, w, h, $urandom_range(0, 3) == 0, $urandom));
            n = w * h;
            if ($urandom_range(0, 5) == 0)
                n = $urandom_range(0, n - 1);
            else if ($urandom_range(0, 5) == 0)
                n += $urandom_range(1, 2);
            repeat (n) send_word(random_group());
        end
        else if (pick == 7)
        begin
            send_word(make_cmd($urandom, $urandom, $urandom_range(0, 63),
                               $urandom_range(0, 511), 1'($urandom), $urandom));
            repeat ($urandom_range(0, 6)) send_word(random_group());
        end
        else if (pick == 8)
        begin
            if ($urandom_range(0, 1) == 0)
                send_word(make_cmd($urandom, $urandom, 0, $urandom_range(0, 511),
                                   1'($urandom), $urandom));
            else
                send_word(make_cmd($urandom, $urandom, $urandom_range(0, 63), 0,
                                   1'($urandom), $urandom));
            repeat ($urandom_range(1, 2)) send_word(random_group());
        end
        else
            repeat ($urandom_range(1, 3)) send_word(random_group());
    endtask

    task automatic test_random();
        int unsigned stop_at;
        int          clip;
        stop_at = words_taken + RANDOM_WORDS;
        while (words_taken < stop_at)
        begin
            // Now and then drain and move the clip window or the quirk
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: clip = 0;
                    1: clip = 200;
                    2: clip = $urandom_range(150, 199);
                    default: clip = $urandom_range(0, 200);
                endcase
                program_regs(clip, 1'($urandom));
            end
            random_sprite();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_draw();
        test_clipping();
        test_size_limits();
        test_recolor();
        test_lead_quirk();
        test_clip_top_limit();
        program_regs(0, 1'b0);
        test_random();

        // Wait for the last writes, then let the pipeline settle
        in_valid <= 1'b0;
        @(posedge clk);
        for (k = 0; k < DRAIN_CYCLES && pixel_writes_due.size() != 0; k++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pixel_writes_due.size() != 0)
        begin
            $error("%0d pixel writes never arrived", pixel_writes_due.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/psb_pkg.sv
rtl/core/psb_front.sv
rtl/core/psb_queue.sv
rtl/core/psb_back.sv
rtl/core/planar_sprite_blitter_core.sv
rtl/core/psb_checker.sv
tb/planar_sprite_blitter_core_tb.sv
